// ===== src/cpa_pkg.sv =====
// Shared types and constants for the contiguous page allocator.
package cpa_pkg;

  localparam int OPCODE_W = 2;
  localparam int OWNER_ID_W = 8;
  localparam int FIRST_PAGE_W = 12;
  localparam int PAGE_COUNT_W = 13;
  localparam int START_PAGE_W = 12;
  localparam int RESERVED_W = 12;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 16;

  localparam logic [RESERVED_W-1:0] RESERVED_RESET = 12'd256;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_NOSPACE = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC      = 2'd0,
    OP_FREE       = 2'd1,
    OP_FREE_OWNER = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ASCAN,
    ST_AMARK,
    ST_FRUN,
    ST_FOWN,
    ST_RESP
  } state_t;

endpackage

// ===== src/contiguous_page_allocator.sv =====
// First-fit contiguous page allocator over a combined used/owner page memory.
//
//  channel | direction | fields
//  s_*     | in        | tuser: opcode; tdata: owner_id, first_page, page_count
//  m_*     | out       | tuser: status; tdata: start_page
//  cfg_*   | in        | reserved_pages write
//
// Allocate: a search from reserved_pages upward on the single read port, then one
// write per page for page_count pages, then one response. Free run: one write per
// page. Free by owner: one read-modify-write per page over every page, pipelined over
// the registered read. After reset a clearing pass writes every page, with s_tready
// low. One request is worked on at a time; the result waits in the output register
// and a new request is taken while it waits.
module contiguous_page_allocator #(
  parameter int NUM_PAGES  = 4096,
  parameter int OWNER_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [1:0] opcode
  input  logic [cpa_pkg::OPCODE_W-1:0]     s_tuser,
  // [7:0] owner_id, [19:8] first_page, [32:20] page_count, [39:33] zero
  input  logic [cpa_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] status
  output logic                             m_tuser,
  // [11:0] start_page, [15:12] zero
  output logic [cpa_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                             cfg_we,
  input  logic [cpa_pkg::RESERVED_W-1:0]   cfg_data
);

  localparam int PB = $clog2(NUM_PAGES);
  localparam int CNT_BITS = $clog2(NUM_PAGES + 1);
  localparam int W = (CNT_BITS > 14) ? CNT_BITS : 14;
  localparam int MW = OWNER_BITS + 1;
  localparam logic [W-1:0] NP = W'(NUM_PAGES);
  localparam logic [W-1:0] LAST = W'(NUM_PAGES - 1);

  cpa_pkg::state_t state, state_next;

  logic [MW-1:0] mem [NUM_PAGES];
  logic [MW-1:0] mem_rdata;
  logic          mem_we;
  logic          mem_re;
  logic [PB-1:0] mem_waddr;
  logic [PB-1:0] mem_raddr;
  logic [MW-1:0] mem_wdata;

  logic [cpa_pkg::RESERVED_W-1:0]   reserved;
  logic [W-1:0]                     ptr;
  logic [cpa_pkg::PAGE_COUNT_W-1:0] rem;
  logic [W-1:0]                     run;
  logic [PB-1:0]                    run_start;
  logic [PB-1:0]                    chk_idx;
  logic                             rvalid;
  logic [OWNER_BITS-1:0]            owner_q;
  logic                             res_status;
  logic [cpa_pkg::START_PAGE_W-1:0] res_start;
  logic                             out_valid;
  logic                             out_status;
  logic [cpa_pkg::START_PAGE_W-1:0] out_start;

  logic                             accept;
  cpa_pkg::op_t                     in_op;
  logic                             issue;
  logic                             scan_free;
  logic [W-1:0]                     run_inc;
  logic                             found;
  logic                             fail;
  logic [PB-1:0]                    cand;
  logic                             chk_last;
  logic                             res_load;

  assign in_op     = cpa_pkg::op_t'(s_tuser);
  assign s_tready  = (state == cpa_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign issue     = ((state == cpa_pkg::ST_ASCAN) || (state == cpa_pkg::ST_FOWN)) && (ptr < NP);
  assign scan_free = !mem_rdata[OWNER_BITS];
  assign run_inc   = run + W'(1);
  assign found     = (state == cpa_pkg::ST_ASCAN) && rvalid && scan_free && (run_inc >= W'(rem));
  assign chk_last  = (W'(chk_idx) == LAST);
  assign fail      = (state == cpa_pkg::ST_ASCAN) && rvalid && chk_last && !found;
  assign cand      = (run == '0) ? chk_idx : run_start;
  assign res_load  = (state == cpa_pkg::ST_RESP) && (!out_valid || m_tready);

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{(cpa_pkg::M_TDATA_W - cpa_pkg::START_PAGE_W){1'b0}}, out_start};

  always_comb begin
    state_next = state;
    case (state)
      cpa_pkg::ST_CLEAR: begin
        if (ptr == LAST) state_next = cpa_pkg::ST_IDLE;
      end
      cpa_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_op)
            cpa_pkg::OP_ALLOC: begin
              if (W'(reserved) >= NP) state_next = cpa_pkg::ST_RESP;
              else state_next = cpa_pkg::ST_ASCAN;
            end
            cpa_pkg::OP_FREE:       state_next = cpa_pkg::ST_FRUN;
            cpa_pkg::OP_FREE_OWNER: state_next = cpa_pkg::ST_FOWN;
            default:                state_next = cpa_pkg::ST_RESP;
          endcase
        end
      end
      cpa_pkg::ST_ASCAN: begin
        if (found) begin
          if (rem == '0) state_next = cpa_pkg::ST_RESP;
          else state_next = cpa_pkg::ST_AMARK;
        end else if (fail) begin
          state_next = cpa_pkg::ST_RESP;
        end
      end
      cpa_pkg::ST_AMARK: begin
        if (rem == cpa_pkg::PAGE_COUNT_W'(1)) state_next = cpa_pkg::ST_RESP;
      end
      cpa_pkg::ST_FRUN: begin
        if ((rem == '0) || (ptr >= NP)) state_next = cpa_pkg::ST_RESP;
      end
      cpa_pkg::ST_FOWN: begin
        if (rvalid && chk_last) state_next = cpa_pkg::ST_RESP;
      end
      cpa_pkg::ST_RESP: begin
        if (res_load) state_next = cpa_pkg::ST_IDLE;
      end
      default: state_next = cpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = ptr[PB-1:0];
    mem_raddr = ptr[PB-1:0];
    mem_wdata = '0;
    case (state)
      cpa_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      cpa_pkg::ST_ASCAN: begin
        mem_re = issue;
      end
      cpa_pkg::ST_AMARK: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, owner_q};
      end
      cpa_pkg::ST_FRUN: begin
        mem_we = (rem != '0) && (ptr < NP);
      end
      cpa_pkg::ST_FOWN: begin
        mem_re    = issue;
        mem_we    = rvalid && (mem_rdata[OWNER_BITS-1:0] == owner_q);
        mem_waddr = chk_idx;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cpa_pkg::ST_CLEAR;
      reserved  <= cpa_pkg::RESERVED_RESET;
      ptr       <= '0;
      rvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rvalid  <= issue;
      chk_idx <= ptr[PB-1:0];
      if (cfg_we) reserved <= cfg_data;
      if (res_load) begin
        out_valid  <= 1'b1;
        out_status <= res_status;
        out_start  <= res_start;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        cpa_pkg::ST_CLEAR: begin
          ptr <= ptr + W'(1);
        end
        cpa_pkg::ST_IDLE: begin
          if (accept) begin
            owner_q    <= OWNER_BITS'(s_tdata[7:0]);
            rem        <= s_tdata[32:20];
            run        <= '0;
            res_start  <= '0;
            res_status <= cpa_pkg::STATUS_DONE;
            case (in_op)
              cpa_pkg::OP_ALLOC: begin
                ptr <= W'(reserved);
                if (W'(reserved) >= NP) res_status <= cpa_pkg::STATUS_NOSPACE;
              end
              cpa_pkg::OP_FREE: ptr <= W'(s_tdata[19:8]);
              default:          ptr <= '0;
            endcase
          end
        end
        cpa_pkg::ST_ASCAN: begin
          if (issue) ptr <= ptr + W'(1);
          if (rvalid) begin
            if (scan_free) begin
              run <= run_inc;
              if (run == '0) run_start <= chk_idx;
            end else begin
              run <= '0;
            end
          end
          if (found) begin
            ptr       <= W'(cand);
            res_start <= cpa_pkg::START_PAGE_W'(cand);
          end
          if (fail) res_status <= cpa_pkg::STATUS_NOSPACE;
        end
        cpa_pkg::ST_AMARK, cpa_pkg::ST_FRUN: begin
          ptr <= ptr + W'(1);
          rem <= rem - cpa_pkg::PAGE_COUNT_W'(1);
        end
        cpa_pkg::ST_FOWN: begin
          if (issue) ptr <= ptr + W'(1);
        end
        default: begin
          ptr <= ptr;
        end
      endcase
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == cpa_pkg::ST_IDLE) |-> !mem_we)
    else $error("page memory written while idle");

  a_own_addr: assert property (@(posedge clk) disable iff (rst)
    (state == cpa_pkg::ST_FOWN && rvalid) |-> (chk_idx == $past(mem_raddr)))
    else $error("owner scan write address does not follow read address");

  a_mark_used: assert property (@(posedge clk) disable iff (rst)
    (state == cpa_pkg::ST_AMARK) |-> (mem_we && mem_wdata[OWNER_BITS] && (ptr < NP)))
    else $error("allocation mark missing or out of range");

  a_resp_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == cpa_pkg::ST_RESP))
    else $error("result transfer raised outside response state");

endmodule

// ===== sim/testbench.sv =====
// Testbench for the contiguous page allocator: directed and random requests checked against a page map.
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_PAGES = 4096;
  localparam int LIMIT_CYCLES = 6000000;

  typedef struct packed {
    logic                             status;
    logic [cpa_pkg::START_PAGE_W-1:0] start_page;
  } reply_t;

  typedef struct packed {
    logic [cpa_pkg::FIRST_PAGE_W-1:0] first;
    logic [cpa_pkg::PAGE_COUNT_W-1:0] count;
  } run_t;

  class page_map_tracker;
    bit                             used[NUM_PAGES];
    bit [cpa_pkg::OWNER_ID_W-1:0]   owner_of[NUM_PAGES];
    logic [cpa_pkg::RESERVED_W-1:0] reserved = cpa_pkg::RESERVED_RESET;
    reply_t                         expected_replies[$];
    run_t                           granted_runs[$];
    int                             mismatch_count = 0;

    function void note_request(cpa_pkg::op_t op, logic [cpa_pkg::OWNER_ID_W-1:0] own,
                               logic [cpa_pkg::FIRST_PAGE_W-1:0] first,
                               logic [cpa_pkg::PAGE_COUNT_W-1:0] cnt);
      int     p;
      int     run;
      int     run_start;
      bit     found;
      reply_t r;
      run_t   g;
      r.status = cpa_pkg::STATUS_DONE;
      r.start_page = '0;
      case (op)
        cpa_pkg::OP_ALLOC: begin
          run = 0;
          run_start = 0;
          found = 1'b0;
          for (p = int'(reserved); p < NUM_PAGES && !found; p++) begin
            if (!used[p]) begin
              if (run == 0) run_start = p;
              run++;
              if (run >= int'(cnt)) found = 1'b1;
            end else begin
              run = 0;
            end
          end
          if (found) begin
            for (p = run_start; p < run_start + int'(cnt) && p < NUM_PAGES; p++) begin
              used[p] = 1'b1;
              owner_of[p] = own;
            end
            r.start_page = run_start[cpa_pkg::START_PAGE_W-1:0];
            if (cnt != '0) begin
              g.first = run_start[cpa_pkg::FIRST_PAGE_W-1:0];
              g.count = cnt;
              granted_runs.push_back(g);
              if (granted_runs.size() > 64) void'(granted_runs.pop_front());
            end
          end else begin
            r.status = cpa_pkg::STATUS_NOSPACE;
          end
        end
        cpa_pkg::OP_FREE: begin
          for (p = int'(first); p < int'(first) + int'(cnt) && p < NUM_PAGES; p++) begin
            used[p] = 1'b0;
            owner_of[p] = '0;
          end
        end
        cpa_pkg::OP_FREE_OWNER: begin
          for (p = 0; p < NUM_PAGES; p++) begin
            if (owner_of[p] == own) begin
              used[p] = 1'b0;
              owner_of[p] = '0;
            end
          end
        end
        default: ;
      endcase
      expected_replies.push_back(r);
    endfunction

    function void check_reply(logic status, logic [cpa_pkg::START_PAGE_W-1:0] start_page);
      reply_t want;
      if (expected_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected reply: status %0d start_page %0d", status, start_page);
        return;
      end
      want = expected_replies.pop_front();
      if (want.status !== status || want.start_page !== start_page) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: status exp %0d act %0d, start_page exp %0d act %0d",
                   want.status, status, want.start_page, start_page);
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [cpa_pkg::OPCODE_W-1:0]     s_tuser = '0;
  logic [cpa_pkg::S_TDATA_W-1:0]    s_tdata = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic                             m_tuser;
  logic [cpa_pkg::M_TDATA_W-1:0]    m_tdata;
  logic                             cfg_we = 1'b0;
  logic [cpa_pkg::RESERVED_W-1:0]   cfg_data = '0;

  int src_idle_pct = 31;
  int sink_idle_pct = 53;

  page_map_tracker tracker = new();

  contiguous_page_allocator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        tracker.check_reply(m_tuser, m_tdata[cpa_pkg::START_PAGE_W-1:0]);
      if (s_tvalid && s_tready)
        tracker.note_request(cpa_pkg::op_t'(s_tuser), s_tdata[7:0], s_tdata[19:8],
                             s_tdata[32:20]);
    end
  end

  task automatic send_request(cpa_pkg::op_t op, logic [cpa_pkg::OWNER_ID_W-1:0] own,
                              logic [cpa_pkg::FIRST_PAGE_W-1:0] first,
                              logic [cpa_pkg::PAGE_COUNT_W-1:0] cnt);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {7'd0, cnt, first, own};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reserved(logic [cpa_pkg::RESERVED_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    tracker.reserved = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_request();
    int                               pick;
    run_t                             r;
    cpa_pkg::op_t                     op;
    logic [cpa_pkg::OWNER_ID_W-1:0]   own;
    logic [cpa_pkg::FIRST_PAGE_W-1:0] first;
    logic [cpa_pkg::PAGE_COUNT_W-1:0] cnt;
    pick = $urandom_range(99);
    own = cpa_pkg::OWNER_ID_W'($urandom_range(1, 7));
    first = cpa_pkg::FIRST_PAGE_W'($urandom_range(0, 4095));
    cnt = cpa_pkg::PAGE_COUNT_W'($urandom_range(1, 48));
    if ($urandom_range(9) == 0) own = cpa_pkg::OWNER_ID_W'($urandom_range(0, 255));
    if ($urandom_range(9) == 0) cnt = cpa_pkg::PAGE_COUNT_W'($urandom_range(49, 700));
    else if ($urandom_range(19) == 0) cnt = cpa_pkg::PAGE_COUNT_W'($urandom_range(0, 8191));
    else if ($urandom_range(24) == 0) cnt = '0;
    if (pick < 50) begin
      op = cpa_pkg::OP_ALLOC;
    end else if (pick < 72) begin
      op = cpa_pkg::OP_FREE;
      if (tracker.granted_runs.size() != 0 && $urandom_range(4) != 0) begin
        r = tracker.granted_runs[$urandom_range(tracker.granted_runs.size() - 1)];
        first = r.first;
        cnt = r.count;
      end
    end else if (pick < 90) begin
      op = cpa_pkg::OP_FREE_OWNER;
      own = cpa_pkg::OWNER_ID_W'($urandom_range(0, 7));
    end else begin
      op = cpa_pkg::op_t'($urandom_range(0, 3));
    end
    send_request(op, own, first, cnt);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    set_reserved(cpa_pkg::RESERVED_RESET);

    send_request(cpa_pkg::OP_ALLOC, 8'd1, 12'd0, 13'd1);
    send_request(cpa_pkg::OP_ALLOC, 8'd2, 12'd0, 13'd0);
    send_request(cpa_pkg::OP_ALLOC, 8'd255, 12'd0, 13'd4096);
    send_request(cpa_pkg::OP_ALLOC, 8'd255, 12'd4095, 13'd8191);
    send_request(cpa_pkg::OP_ALLOC, 8'd3, 12'd0, 13'd3839);
    send_request(cpa_pkg::OP_ALLOC, 8'd4, 12'd0, 13'd1);
    send_request(cpa_pkg::OP_FREE, 8'd0, 12'd4000, 13'd200);
    send_request(cpa_pkg::OP_ALLOC, 8'd4, 12'd0, 13'd96);
    send_request(cpa_pkg::OP_FREE_OWNER, 8'd3, 12'd0, 13'd1);
    send_request(cpa_pkg::OP_FREE, 8'd0, 12'd4095, 13'd8191);
    send_request(cpa_pkg::OP_FREE, 8'd0, 12'd0, 13'd16);
    send_request(cpa_pkg::OP_FREE_OWNER, 8'd0, 12'd0, 13'd1);
    send_request(cpa_pkg::OP_NONE, 8'd255, 12'd4095, 13'd8191);
    send_request(cpa_pkg::OP_ALLOC, 8'd0, 12'd0, 13'd0);
    drain();

    set_reserved(12'd4095);
    send_request(cpa_pkg::OP_ALLOC, 8'd7, 12'd0, 13'd1);
    send_request(cpa_pkg::OP_ALLOC, 8'd7, 12'd0, 13'd0);
    send_request(cpa_pkg::OP_ALLOC, 8'd7, 12'd0, 13'd2);
    send_request(cpa_pkg::OP_FREE_OWNER, 8'd7, 12'd0, 13'd1);
    send_request(cpa_pkg::OP_FREE_OWNER, 8'd255, 12'd0, 13'd1);
    drain();

    set_reserved(12'd1);
    repeat (20) send_random_request();
    drain();
    repeat (20) send_random_request();
    drain();

    src_idle_pct = 53;
    sink_idle_pct = 31;
    set_reserved(cpa_pkg::RESERVED_W'($urandom_range(2, 3000)));
    repeat (40) send_random_request();
    drain();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    set_reserved(cpa_pkg::RESERVED_RESET);
    repeat (41) send_random_request();
    drain();

    if (tracker.mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
